### sv/partitioned_multi_stack_core_assert.svh
// assertion helpers, clocked on clk and disabled during reset
`ifndef PARTITIONED_MULTI_STACK_CORE_ASSERT_SVH
`define PARTITIONED_MULTI_STACK_CORE_ASSERT_SVH

// same-cycle implication
`define PMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pms_pkg.sv
package pms_pkg;

  localparam int STACK_COUNT = 4;
  localparam int TOTAL_DEPTH = 32;
  localparam int DATA_WIDTH  = 16;

  localparam int SEG_SIZE = TOTAL_DEPTH / STACK_COUNT;
  localparam int ADDR_W   = $clog2(TOTAL_DEPTH);
  localparam int FILL_W   = $clog2(SEG_SIZE + 2);
  localparam int IDX_W    = $clog2(STACK_COUNT);

  // port field widths
  localparam int CMD_W     = 2;
  localparam int SEL_W     = 4;
  localparam int VAL_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 4;
  localparam int SEL_CMP_W = SEL_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_NOP
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY,
    STAT_BAD
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WB
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

endpackage

### sv/pms_datapath.sv
module pms_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pms_pkg::ctrl_cmd_t         ctrl,
  input  logic [pms_pkg::CMD_W-1:0]  in_command,
  input  logic [pms_pkg::SEL_W-1:0]  in_stack_sel,
  input  logic [pms_pkg::VAL_W-1:0]  in_push_value,
  output logic [pms_pkg::VAL_W-1:0]  out_top_value,
  output logic [pms_pkg::STATUS_W-1:0] out_status,
  output logic [pms_pkg::CNT_W-1:0]  out_fill_count
);

  logic [pms_pkg::DATA_WIDTH-1:0] mem [pms_pkg::TOTAL_DEPTH];
  logic [pms_pkg::FILL_W-1:0]     stack_fill_r [pms_pkg::STACK_COUNT];

  pms_pkg::cmd_t                  cmd_r;
  logic [pms_pkg::IDX_W-1:0]      idx_r;
  logic                           bad_r;
  logic [pms_pkg::DATA_WIDTH-1:0] val_r;
  logic [pms_pkg::FILL_W-1:0]     n_r;

  logic [pms_pkg::DATA_WIDTH-1:0] rd_data_r;
  logic                           res_rd_r;
  pms_pkg::status_t               res_status_r;
  logic [pms_pkg::FILL_W-1:0]     res_fill_r;

  logic [pms_pkg::VAL_W-1:0]      top_r;
  pms_pkg::status_t               status_r;
  logic [pms_pkg::CNT_W-1:0]      cnt_r;

  logic                           in_bad;
  logic [pms_pkg::ADDR_W-1:0]     base;
  logic [pms_pkg::ADDR_W-1:0]     addr;
  logic                           wr_en;
  logic                           rd_en;
  logic                           fill_we;
  logic [pms_pkg::FILL_W-1:0]     fill_nxt;
  pms_pkg::status_t               status_nxt;

  assign in_bad = pms_pkg::SEL_CMP_W'(in_stack_sel)
                  >= pms_pkg::SEL_CMP_W'(pms_pkg::STACK_COUNT);

  // capture the word and the selected stack's count
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= pms_pkg::cmd_t'(in_command);
      idx_r <= in_stack_sel[pms_pkg::IDX_W-1:0];
      bad_r <= in_bad;
      val_r <= pms_pkg::DATA_WIDTH'(in_push_value);
      n_r   <= in_bad ? '0 : stack_fill_r[in_stack_sel[pms_pkg::IDX_W-1:0]];
    end
  end

  assign base = pms_pkg::ADDR_W'(idx_r * pms_pkg::SEG_SIZE);

  // push writes just above the top, pop and peek read the top
  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    fill_we    = 1'b0;
    fill_nxt   = n_r;
    status_nxt = pms_pkg::STAT_OK;
    if (cmd_r == pms_pkg::CMD_PUSH) begin
      addr = base + pms_pkg::ADDR_W'(n_r);
    end else begin
      addr = base + pms_pkg::ADDR_W'(n_r) - pms_pkg::ADDR_W'(1);
    end
    if (bad_r) begin
      status_nxt = pms_pkg::STAT_BAD;
      fill_nxt   = '0;
    end else begin
      unique case (cmd_r)
        pms_pkg::CMD_PUSH: begin
          if (n_r >= pms_pkg::FILL_W'(pms_pkg::SEG_SIZE)) begin
            status_nxt = pms_pkg::STAT_FULL;
          end else begin
            wr_en    = ctrl.exec;
            fill_we  = ctrl.exec;
            fill_nxt = n_r + 1'b1;
          end
        end
        pms_pkg::CMD_POP, pms_pkg::CMD_PEEK: begin
          if (n_r == '0) begin
            status_nxt = pms_pkg::STAT_EMPTY;
          end else begin
            rd_en = ctrl.exec;
            if (cmd_r == pms_pkg::CMD_POP) begin
              fill_we  = ctrl.exec;
              fill_nxt = n_r - 1'b1;
            end
          end
        end
        pms_pkg::CMD_NOP: begin
          status_nxt = pms_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pms_pkg::STACK_COUNT; i++) begin
        stack_fill_r[i] <= '0;
      end
    end else if (fill_we) begin
      stack_fill_r[idx_r] <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_rd_r     <= rd_en;
      res_status_r <= status_nxt;
      res_fill_r   <= fill_nxt;
    end
  end

  // output register, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      top_r    <= res_rd_r ? pms_pkg::VAL_W'(rd_data_r) : '0;
      status_r <= res_status_r;
      cnt_r    <= pms_pkg::CNT_W'(res_fill_r);
    end
  end

  assign out_top_value  = top_r;
  assign out_status     = status_r;
  assign out_fill_count = cnt_r;

endmodule

### sv/pms_ctrl.sv
module pms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output pms_pkg::ctrl_cmd_t ctrl
);

  `include "partitioned_multi_stack_core_assert.svh"

  pms_pkg::state_t state_r;
  pms_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pms_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pms_pkg::ST_EXEC;
        end
      end
      pms_pkg::ST_EXEC: begin
        state_nxt = pms_pkg::ST_WB;
      end
      pms_pkg::ST_WB: begin
        if (slot_free) begin
          state_nxt = pms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = (state_r != pms_pkg::ST_IDLE);
    ctrl.capture  = (state_r == pms_pkg::ST_IDLE) && in_valid;
    ctrl.exec     = (state_r == pms_pkg::ST_EXEC);
    ctrl.load_out = (state_r == pms_pkg::ST_WB) && slot_free;
  end

  always_comb begin
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PMS_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == pms_pkg::ST_EXEC,
                   "accepted word did not start execution")
  `PMS_ASSERT_NEXT(a_exec_wb, state_r == pms_pkg::ST_EXEC, state_r == pms_pkg::ST_WB,
                   "execute did not move to write-back")
  `PMS_ASSERT_NOW(a_load_free, ctrl.load_out, !out_valid_r || !out_stall,
                  "result loaded over a stalled word")
  `PMS_ASSERT_NOW(a_valid_src, $rose(out_valid_r), $past(state_r) == pms_pkg::ST_WB,
                  "output valid rose outside write-back")

endmodule

### sv/partitioned_multi_stack_core.sv
// Several stacks in one shared store, each owning a fixed equal segment.
// Each input word is a push, pop, peek or no-op on one stack and yields
// exactly one result word with the top value, a status (ok, full, empty,
// bad stack) and the stack's fill count afterwards. An item is handled in
// turn: the accepting cycle captures the word with the count lookup, the
// next does the one access of the single-port store, and write-back then
// loads the result register once the output slot is free.
// The next item is accepted once the result is loaded, while the result may
// still sit stalled at the output.
// The store needs no clearing after reset; only the per-stack counts reset.
module partitioned_multi_stack_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pms_pkg::CMD_W-1:0]    in_command,
  input  logic [pms_pkg::SEL_W-1:0]    in_stack_sel,
  input  logic [pms_pkg::VAL_W-1:0]    in_push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pms_pkg::VAL_W-1:0]    out_top_value,
  output logic [pms_pkg::STATUS_W-1:0] out_status,
  output logic [pms_pkg::CNT_W-1:0]    out_fill_count
);

  pms_pkg::ctrl_cmd_t ctrl;

  pms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  pms_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_command     (in_command),
    .in_stack_sel   (in_stack_sel),
    .in_push_value  (in_push_value),
    .out_top_value  (out_top_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [pms_pkg::VAL_W-1:0] top_value;
    pms_pkg::status_t          status;
    logic [pms_pkg::CNT_W-1:0] fill_count;
  } stack_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [pms_pkg::CMD_W-1:0]    in_command = '0;
  logic [pms_pkg::SEL_W-1:0]    in_stack_sel = '0;
  logic [pms_pkg::VAL_W-1:0]    in_push_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [pms_pkg::VAL_W-1:0]    out_top_value;
  logic [pms_pkg::STATUS_W-1:0] out_status;
  logic [pms_pkg::CNT_W-1:0]    out_fill_count;

  // shadow copy of the stacks
  logic [pms_pkg::VAL_W-1:0] shadow_mem [pms_pkg::TOTAL_DEPTH];
  int                        shadow_fill [pms_pkg::STACK_COUNT];

  stack_result_t pending_results [$];
  stack_result_t want;
  bit            idle_en = 1'b1;
  int            fail_count = 0;
  int            cmds_issued = 0;
  int            results_seen = 0;
  int            status_seen [4] = '{0, 0, 0, 0};

  partitioned_multi_stack_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_status    (out_status),
    .out_fill_count(out_fill_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stack_result_t apply_stack_op(pms_pkg::cmd_t op,
                                                   logic [pms_pkg::SEL_W-1:0] sel,
                                                   logic [pms_pkg::VAL_W-1:0] value);
    stack_result_t r;
    int            n;
    int            base;
    r.top_value  = '0;
    r.status     = pms_pkg::STAT_OK;
    r.fill_count = '0;
    if (sel >= pms_pkg::STACK_COUNT) begin
      r.status = pms_pkg::STAT_BAD;
      return r;
    end
    n    = shadow_fill[sel];
    base = sel * pms_pkg::SEG_SIZE;
    case (op)
      pms_pkg::CMD_PUSH: begin
        if (n >= pms_pkg::SEG_SIZE) begin
          r.status = pms_pkg::STAT_FULL;
        end else begin
          shadow_mem[base + n] = value;
          shadow_fill[sel]     = n + 1;
        end
      end
      pms_pkg::CMD_POP, pms_pkg::CMD_PEEK: begin
        if (n == 0) begin
          r.status = pms_pkg::STAT_EMPTY;
        end else begin
          r.top_value = shadow_mem[base + n - 1];
          if (op == pms_pkg::CMD_POP) shadow_fill[sel] = n - 1;
        end
      end
      default: ;
    endcase
    r.fill_count = pms_pkg::CNT_W'(shadow_fill[sel]);
    return r;
  endfunction

  // call right after a rising edge; returns right after the word is taken
  task automatic issue_command(pms_pkg::cmd_t op, logic [pms_pkg::SEL_W-1:0] sel,
                               logic [pms_pkg::VAL_W-1:0] value);
    if (idle_en && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= op;
    in_stack_sel  <= sel;
    in_push_value <= value;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_stack_op(op, sel, value));
    cmds_issued++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected (top %h status %0d fill %0d)",
                 $time, out_top_value, out_status, out_fill_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_top_value !== want.top_value) begin
          $display("%0t: top_value expected %h actual %h", $time, want.top_value,
                   out_top_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_fill_count !== want.fill_count) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                   out_fill_count);
          fail_count++;
        end
      end
    end
    out_stall <= idle_en && ($urandom_range(0, 99) < 15);
  end

  task automatic test_directed();
    // empty pops and peeks, value field ignored
    issue_command(pms_pkg::CMD_POP, 4'd0, 16'h1234);
    issue_command(pms_pkg::CMD_PEEK, 4'd1, 16'hFFFF);
    // extremes of the data word, lifo order
    issue_command(pms_pkg::CMD_PUSH, 4'd0, 16'h0000);
    issue_command(pms_pkg::CMD_PUSH, 4'd0, 16'hFFFF);
    issue_command(pms_pkg::CMD_PEEK, 4'd0, 16'h0000);
    issue_command(pms_pkg::CMD_POP, 4'd0, 16'h0000);
    issue_command(pms_pkg::CMD_POP, 4'd0, 16'h0000);
    issue_command(pms_pkg::CMD_POP, 4'd0, 16'h0000);
    issue_command(pms_pkg::CMD_NOP, 4'd2, 16'hABCD);
    // fill the last stack and push once more
    for (int i = 0; i <= pms_pkg::SEG_SIZE; i++) begin
      issue_command(pms_pkg::CMD_PUSH, pms_pkg::SEL_W'(pms_pkg::STACK_COUNT - 1),
                    pms_pkg::VAL_W'($urandom()));
    end
    issue_command(pms_pkg::CMD_PEEK, pms_pkg::SEL_W'(pms_pkg::STACK_COUNT - 1), 16'h0000);
    issue_command(pms_pkg::CMD_NOP, pms_pkg::SEL_W'(pms_pkg::STACK_COUNT - 1), 16'h0000);
    // bad stack number for every command
    issue_command(pms_pkg::CMD_PUSH, pms_pkg::SEL_W'(pms_pkg::STACK_COUNT), 16'hFFFF);
    issue_command(pms_pkg::CMD_POP, 4'hF, 16'h0000);
    issue_command(pms_pkg::CMD_PEEK, 4'h8, 16'h5A5A);
    issue_command(pms_pkg::CMD_NOP, 4'hF, 16'hFFFF);
  endtask

  // alternating push-heavy and pop-heavy phases, mostly aimed at one stack,
  // so stacks run into both full and empty
  task automatic test_random_mix(int count);
    pms_pkg::cmd_t             op;
    logic [pms_pkg::SEL_W-1:0] sel;
    logic [pms_pkg::VAL_W-1:0] value;
    int                        p;
    int                        push_pct;
    int                        focus;
    bit                        fill_phase;
    fill_phase = 1'b1;
    focus      = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        fill_phase = !fill_phase;
        focus      = int'($urandom_range(0, pms_pkg::STACK_COUNT - 1));
      end
      push_pct = fill_phase ? 55 : 20;
      p = int'($urandom_range(0, 99));
      if (p < push_pct) op = pms_pkg::CMD_PUSH;
      else if (p < push_pct + (fill_phase ? 20 : 50)) op = pms_pkg::CMD_POP;
      else if (p < 90) op = pms_pkg::CMD_PEEK;
      else op = pms_pkg::CMD_NOP;
      p = int'($urandom_range(0, 99));
      if (p < 10) sel = pms_pkg::SEL_W'($urandom_range(pms_pkg::STACK_COUNT, 15));
      else if (p < 70) sel = pms_pkg::SEL_W'(focus);
      else sel = pms_pkg::SEL_W'($urandom_range(0, pms_pkg::STACK_COUNT - 1));
      p = int'($urandom_range(0, 99));
      if (p < 8) value = '0;
      else if (p < 16) value = '1;
      else value = pms_pkg::VAL_W'($urandom());
      issue_command(op, sel, value);
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_en = 1'b0;
    test_random_mix(count);
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(500);
    test_back_to_back(150);
    test_random_mix(450);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("issued %0d stack commands, checked %0d result words", cmds_issued,
             results_seen);
    $display("status seen: ok %0d, full %0d, empty %0d, bad stack %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
